### hdl/tpr_pkg.sv
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types and constants of the tabulated density rejection sampler.
// ----------------------------------------------------------------------------
package tpr_pkg;

  localparam int unsigned ABS_W  = 16;
  localparam int unsigned DENS_W = 15;
  localparam int unsigned UNI_W  = 16;
  localparam int unsigned LOAD_W = 9;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_APPEND  = 2'd1,
    KIND_ATTEMPT = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Classified command passed from the front to the back
  typedef struct packed {
    logic [1:0]        kind;
    logic [ABS_W-1:0]  abscissa;
    logic [DENS_W-1:0] density;
    logic [UNI_W-1:0]  u1;
    logic [UNI_W-1:0]  u2;
  } cmd_t;

  // Queue handshake toward the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

endpackage

### hdl/tpr_if.sv
// ----------------------------------------------------------------------------
// tpr_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface tpr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] point_abscissa;
  logic [15:0] point_density;
  logic [15:0] uniform_one;
  logic [15:0] uniform_two;

  modport source (output valid, kind, point_abscissa, point_density, uniform_one,
                  uniform_two, input ready);
  modport sink (input valid, kind, point_abscissa, point_density, uniform_one,
                uniform_two, output ready);
endinterface

interface tpr_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [15:0] sample_value;
  logic [1:0]  status;
  logic [8:0]  points_loaded;

  modport source (output valid, accepted, sample_value, status, points_loaded,
                  input ready);
  modport sink (input valid, accepted, sample_value, status, points_loaded,
                output ready);
endinterface

### hdl/tpr_front.sv
// ----------------------------------------------------------------------------
// tpr_front
// Accepts items, clamps densities and queues classified commands.
// ----------------------------------------------------------------------------
module tpr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  tpr_in_if.sink               in_ch,
  output tpr_pkg::cmd_q_t      cmd_q,
  input  logic                 cmd_pop
);

  localparam int unsigned QD = 4;
  localparam int unsigned PW = $clog2(QD);

  tpr_pkg::cmd_t  q_r [QD];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PW:0]    fill_r;
  tpr_pkg::cmd_t  cmd_in;
  logic           push;

  // Classify: clamp negative densities to zero
  always_comb begin
    cmd_in.kind     = in_ch.kind;
    cmd_in.abscissa = in_ch.point_abscissa;
    cmd_in.density  = in_ch.point_density[15] ? '0 : in_ch.point_density[14:0];
    cmd_in.u1       = in_ch.uniform_one;
    cmd_in.u2       = in_ch.uniform_two;
  end

  assign in_ch.ready = (fill_r != (PW+1)'(QD));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_q.valid = (fill_r != '0);
  assign cmd_q.cmd   = q_r[rd_ptr_r];

  // Store queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (cmd_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      fill_r <= fill_r + (PW+1)'(push) - (PW+1)'(cmd_pop);
    end
  end

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (PW+1)'(QD)) else $error("queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_q.valid) else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !cmd_pop) |=> fill_r == $past(fill_r) + 1'b1)
    else $error("fill level not advanced on push");

endmodule

### hdl/tpr_back.sv
// ----------------------------------------------------------------------------
// tpr_back
// Holds the point table and carries out clear, append and attempt commands.
// ----------------------------------------------------------------------------
module tpr_back #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tpr_pkg::cmd_q_t cmd_q,
  output logic            cmd_pop,
  tpr_out_if.source       out_ch
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = tpr_pkg::ABS_W + tpr_pkg::DENS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_LAST, S_SPAN, S_CAND, S_SRCH, S_NEXT, S_MUL1, S_MUL2, S_CMP
  } state_t;

  state_t          state_r;
  logic [EW-1:0]   mem_r [TABLE_DEPTH];
  logic [EW-1:0]   rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;

  logic [CW-1:0]   count_r;
  logic [14:0]     max_r;
  logic [15:0]     u1_r, u2_r, x0_r, cand_r, xj_r, dx_r, off_r;
  logic [14:0]     fj_r, fk_r;
  logic [31:0]     prod_r;
  logic [AW-1:0]   j_r;
  logic            dx_pos_r;
  logic [30:0]     pa_r, pb_r;
  logic signed [32:0] pc_r;
  logic [46:0]     lhs_r;
  logic signed [33:0] rhs_r;

  logic        out_valid_r, out_acc_r;
  logic [15:0] out_val_r;
  logic [1:0]  out_st_r;
  logic [8:0]  out_load_r;

  logic        out_valid_nxt;
  logic [1:0]  out_st_nxt;
  logic [8:0]  out_load_nxt;
  logic        start_attempt;

  logic [15:0] rd_x;
  logic [14:0] rd_f;
  logic signed [16:0] span, dx;
  logic        out_free, full, search_go;
  logic signed [50:0] lhs_s, rhs_s;
  logic [CW-1:0] count_m1, count_m2;

  assign rd_x     = rd_data_r[EW-1:tpr_pkg::DENS_W];
  assign rd_f     = rd_data_r[tpr_pkg::DENS_W-1:0];
  assign out_free = !out_valid_r || out_ch.ready;
  assign full     = (count_r >= CW'(TABLE_DEPTH));
  assign cmd_pop  = (state_r == S_IDLE) && cmd_q.valid && out_free;
  assign wr_en    = cmd_pop && (cmd_q.cmd.kind == tpr_pkg::KIND_APPEND) && !full;
  assign span     = $signed({1'b0, rd_x}) - $signed({1'b0, x0_r});
  assign dx       = $signed({1'b0, rd_x}) - $signed({1'b0, xj_r});
  assign search_go = (j_r != '0) && (rd_x > cand_r);
  assign count_m1 = count_r - 1'b1;
  assign count_m2 = count_r - CW'(2);
  assign lhs_s    = $signed({4'b0, lhs_r});
  assign rhs_s    = $signed({rhs_r, 16'b0}) >>> 0;

  // Select the table read address
  always_comb begin
    rd_addr = '0;
    case (state_r)
      S_RD_LAST: rd_addr = count_m1[AW-1:0];
      S_CAND:    rd_addr = count_m2[AW-1:0];
      S_SRCH:    rd_addr = search_go ? j_r - 1'b1 : j_r + 1'b1;
      default:   rd_addr = '0;
    endcase
  end

  // Decode the popped command into its immediate result
  always_comb begin
    out_st_nxt    = tpr_pkg::STATUS_OK;
    out_load_nxt  = 9'(count_r);
    start_attempt = 1'b0;
    case (cmd_q.cmd.kind)
      tpr_pkg::KIND_CLEAR: out_load_nxt = '0;
      tpr_pkg::KIND_APPEND: begin
        if (full) begin
          out_st_nxt = tpr_pkg::STATUS_FULL;
        end else begin
          out_load_nxt = 9'(count_r + 1'b1);
        end
      end
      tpr_pkg::KIND_ATTEMPT: begin
        if (count_r < CW'(2)) begin
          out_st_nxt = tpr_pkg::STATUS_SHORT;
        end else begin
          start_attempt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Hold the result until its transfer, raise it when a command finishes
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if ((cmd_pop && !start_attempt) || (state_r == S_CMP)) out_valid_nxt = 1'b1;
  end

  // Table storage with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[count_r[AW-1:0]] <= {cmd_q.cmd.abscissa, cmd_q.cmd.density};
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Sequence commands and hold the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            out_acc_r  <= 1'b0;
            out_val_r  <= '0;
            out_st_r   <= out_st_nxt;
            out_load_r <= out_load_nxt;
            u1_r <= cmd_q.cmd.u1;
            u2_r <= cmd_q.cmd.u2;
            if (start_attempt) state_r <= S_RD_LAST;
            case (cmd_q.cmd.kind)
              tpr_pkg::KIND_CLEAR: begin
                count_r <= '0;
                max_r   <= '0;
              end
              tpr_pkg::KIND_APPEND: begin
                if (!full) begin
                  count_r <= count_r + 1'b1;
                  if (cmd_q.cmd.density > max_r) max_r <= cmd_q.cmd.density;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD_LAST: begin
          x0_r    <= rd_x;
          state_r <= S_SPAN;
        end
        S_SPAN: begin
          prod_r  <= (span > 0) ? u1_r * span[15:0] : '0;
          state_r <= S_CAND;
        end
        S_CAND: begin
          cand_r  <= x0_r + prod_r[31:16];
          j_r     <= count_m2[AW-1:0];
          state_r <= S_SRCH;
        end
        S_SRCH: begin
          if (search_go) begin
            j_r <= j_r - 1'b1;
          end else begin
            xj_r    <= rd_x;
            fj_r    <= rd_f;
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          dx_pos_r <= (dx > 0);
          dx_r     <= dx[15:0];
          off_r    <= cand_r - xj_r;
          fk_r     <= rd_f;
          state_r  <= S_MUL1;
        end
        S_MUL1: begin
          pa_r    <= u2_r * max_r;
          pb_r    <= fj_r * dx_r;
          pc_r    <= ($signed({1'b0, fk_r}) - $signed({1'b0, fj_r}))
                     * $signed({1'b0, off_r});
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          if (dx_pos_r) begin
            lhs_r <= pa_r * dx_r;
            rhs_r <= $signed({3'b0, pb_r}) + 34'(pc_r);
          end else begin
            lhs_r <= 47'(pa_r);
            rhs_r <= $signed({19'b0, fj_r});
          end
          state_r <= S_CMP;
        end
        S_CMP: begin
          out_acc_r <= (lhs_s <= rhs_s);
          out_val_r <= cand_r;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.accepted      = out_acc_r;
  assign out_ch.sample_value  = out_val_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.points_loaded = out_load_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("point count beyond table");
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_RD_LAST) |-> !out_valid_r)
    else $error("result pending during attempt");
  a_acc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_acc_r) |-> out_st_r == tpr_pkg::STATUS_OK)
    else $error("accepted with bad status");
  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH |-> CW'(j_r) <= count_m2)
    else $error("search index out of range");

endmodule

### hdl/tabulated_pdf_rejection_sampler_core.sv
// ----------------------------------------------------------------------------
// tabulated_pdf_rejection_sampler_core
// Rejection sampler over a piecewise-linear density table.
// ----------------------------------------------------------------------------
// Every item gives one result. Clear, append and unused kinds finish at their
// pop in the back end. An attempt holds the back end while it reads the last
// point, forms the candidate, walks down to its segment and compares: the
// downward segment walk reads one table entry per cycle through the single
// table read port, and the compare uses two registered multiply steps and a
// registered compare. A four-entry command queue lets the input side keep
// accepting items while an attempt runs. A waiting result holds the back end
// until it transfers; the next command starts in that same cycle.
module tabulated_pdf_rejection_sampler_core #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  tpr_in_if.sink     in_ch,
  tpr_out_if.source  out_ch
);

  tpr_pkg::cmd_q_t cmd_q;
  logic            cmd_pop;

  tpr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cmd_q   (cmd_q),
    .cmd_pop (cmd_pop)
  );

  tpr_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_q   (cmd_q),
    .cmd_pop (cmd_pop),
    .out_ch  (out_ch)
  );

endmodule

### test/tb_tabulated_pdf_rejection_sampler_core.sv
// ----------------------------------------------------------------------------
// tb_tabulated_pdf_rejection_sampler_core
// Drives clear, append and attempt items through the sampler core, predicts
// each result from an internal copy of the table and checks every result
// transfer in order, under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
typedef struct {
  logic        accepted;
  logic [15:0] sample_value;
  logic [1:0]  status;
  logic [8:0]  points_loaded;
} sample_res_t;

class sampler_scoreboard;
  logic [15:0] abs_tab [256];
  logic [14:0] dens_tab [256];
  int unsigned n_points;
  logic [14:0] peak_dens;
  sample_res_t pending [$];
  int unsigned errors;

  function new();
    n_points  = 0;
    peak_dens = 0;
    errors    = 0;
  endfunction

  // Predict the result of one accepted input transfer
  function void note_item(logic [1:0] kind, logic [15:0] xa, logic [15:0] dens,
                          logic [15:0] u1, logic [15:0] u2);
    sample_res_t r;
    longint x0, xl, span, cand, dx, off, fj, fk, lhs, rhs;
    int j;
    r.accepted = 1'b0;
    r.sample_value = '0;
    r.status = tpr_pkg::STATUS_OK;
    if (kind == tpr_pkg::KIND_CLEAR) begin
      n_points  = 0;
      peak_dens = 0;
    end else if (kind == tpr_pkg::KIND_APPEND) begin
      if (n_points >= 256) begin
        r.status = tpr_pkg::STATUS_FULL;
      end else begin
        abs_tab[n_points]  = xa;
        dens_tab[n_points] = dens[15] ? 15'd0 : dens[14:0];
        if (dens_tab[n_points] > peak_dens) peak_dens = dens_tab[n_points];
        n_points++;
      end
    end else if (kind == tpr_pkg::KIND_ATTEMPT) begin
      if (n_points < 2) begin
        r.status = tpr_pkg::STATUS_SHORT;
      end else begin
        x0 = abs_tab[0];
        xl = abs_tab[n_points-1];
        span = xl - x0;
        cand = (span > 0) ? x0 + ((longint'(u1) * span) >>> 16) : x0;
        j = n_points - 2;
        while (j > 0 && longint'(abs_tab[j]) > cand) j--;
        fj = dens_tab[j];
        fk = dens_tab[j+1];
        dx = longint'(abs_tab[j+1]) - longint'(abs_tab[j]);
        off = cand - longint'(abs_tab[j]);
        if (dx > 0) begin
          lhs = longint'(u2) * longint'(peak_dens) * dx;
          rhs = (fj * dx + (fk - fj) * off) * 65536;
        end else begin
          lhs = longint'(u2) * longint'(peak_dens);
          rhs = fj * 65536;
        end
        r.accepted = (lhs <= rhs);
        r.sample_value = cand[15:0];
      end
    end
    r.points_loaded = n_points[8:0];
    pending = {pending, r};
  endfunction

  task report(string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Compare one result transfer with the oldest prediction
  task check_result(sample_res_t got);
    sample_res_t exp_r;
    if (pending.size() == 0) begin
      report("result with no prediction pending");
      return;
    end
    exp_r = pending.pop_front();
    if (got.accepted !== exp_r.accepted)
      report($sformatf("accepted %0b, predicted %0b", got.accepted, exp_r.accepted));
    if (got.sample_value !== exp_r.sample_value)
      report($sformatf("sample_value %0d, predicted %0d", got.sample_value,
                       exp_r.sample_value));
    if (got.status !== exp_r.status)
      report($sformatf("status %0d, predicted %0d", got.status, exp_r.status));
    if (got.points_loaded !== exp_r.points_loaded)
      report($sformatf("points_loaded %0d, predicted %0d", got.points_loaded,
                       exp_r.points_loaded));
  endtask
endclass

module tb_tabulated_pdf_rejection_sampler_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  longint unsigned cycle_count;
  sampler_scoreboard board;

  tpr_in_if  in_ch ();
  tpr_out_if out_ch ();

  tabulated_pdf_rejection_sampler_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold off the receiver for a counted stretch, else stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    sample_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.accepted      = out_ch.accepted;
      got.sample_value  = out_ch.sample_value;
      got.status        = out_ch.status;
      got.points_loaded = out_ch.points_loaded;
      board.check_result(got);
    end
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("tabulated_pdf_rejection_sampler_core: mismatch");
      $finish;
    end
  end

  // Offer one item and hold it until its transfer
  task automatic send_item(logic [1:0] kind, logic [15:0] xa, logic [15:0] dens,
                           logic [15:0] u1, logic [15:0] u2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.kind           <= kind;
    in_ch.point_abscissa <= xa;
    in_ch.point_density  <= dens;
    in_ch.uniform_one    <= u1;
    in_ch.uniform_two    <= u2;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(kind, xa, dens, u1, u2);
  endtask

  task automatic send_attempt();
    send_item(tpr_pkg::KIND_ATTEMPT, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  // Clear, then load a non-descending table of the given size
  task automatic load_table(int unsigned pts, bit allow_neg);
    logic [15:0] xa;
    logic [15:0] dens;
    int unsigned step;
    xa = 16'($urandom_range(2000));
    send_item(tpr_pkg::KIND_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
    for (int unsigned i = 0; i < pts; i++) begin
      dens = (allow_neg && $urandom_range(7) == 0) ? 16'($urandom) | 16'h8000
                                                  : 16'($urandom_range(32767));
      send_item(tpr_pkg::KIND_APPEND, xa, dens, 16'($urandom), 16'($urandom));
      step = (pts > 32) ? $urandom_range(200) : $urandom_range(3000);
      if ($urandom_range(9) == 0) step = 0;
      xa = (int'(xa) + step > 65535) ? 16'hFFFF : xa + 16'(step);
    end
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned sent;
    int unsigned pick;
    int unsigned pts;
    int unsigned n_try;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pts = $urandom_range(2, 12);
        load_table(pts, 1'b1);
        sent += pts + 1;
        n_try = $urandom_range(4, 12);
        repeat (n_try) send_attempt();
        sent += n_try;
      end else if (pick < 85) begin
        // noise: appends out of order, unused kind, short attempts
        send_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
        sent++;
      end else begin
        send_item(tpr_pkg::KIND_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
        send_attempt();
        send_item(tpr_pkg::KIND_APPEND, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
        send_attempt();
        send_item(tpr_pkg::KIND_APPEND, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
        repeat (3) send_attempt();
        sent += 7;
      end
    end
  endtask

  // Drop valid and wait for every predicted result
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    board = new();
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = tpr_pkg::KIND_CLEAR;
    in_ch.point_abscissa = '0;
    in_ch.point_density = '0;
    in_ch.uniform_one = '0;
    in_ch.uniform_two = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short table, extremes, flat and unordered segments
    send_attempt();
    send_item(tpr_pkg::KIND_APPEND, 16'h0000, 16'h7FFF, 16'h0, 16'h0);
    send_item(tpr_pkg::KIND_ATTEMPT, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF);
    send_item(tpr_pkg::KIND_APPEND, 16'hFFFF, 16'h8000, 16'h0, 16'h0);
    send_item(tpr_pkg::KIND_ATTEMPT, 16'h0, 16'h0, 16'h0000, 16'h0000);
    send_item(tpr_pkg::KIND_ATTEMPT, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF);
    send_item(tpr_pkg::KIND_ATTEMPT, 16'h0, 16'h0, 16'h8000, 16'h7FFF);
    send_item(tpr_pkg::KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(tpr_pkg::KIND_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0);
    send_item(tpr_pkg::KIND_APPEND, 16'd500, 16'd100, 16'h0, 16'h0);
    send_item(tpr_pkg::KIND_APPEND, 16'd500, 16'd300, 16'h0, 16'h0);
    send_item(tpr_pkg::KIND_ATTEMPT, 16'h0, 16'h0, 16'h1234, 16'hFFFF);
    send_item(tpr_pkg::KIND_ATTEMPT, 16'h0, 16'h0, 16'h1234, 16'h0100);
    send_item(tpr_pkg::KIND_APPEND, 16'd200, 16'd50, 16'h0, 16'h0);
    send_item(tpr_pkg::KIND_APPEND, 16'd900, 16'hFFFF, 16'h0, 16'h0);
    send_item(tpr_pkg::KIND_ATTEMPT, 16'h0, 16'h0, 16'hC000, 16'h4000);
    send_item(tpr_pkg::KIND_ATTEMPT, 16'h0, 16'h0, 16'h4000, 16'h0);
    // Full table and dropped points
    load_table(256, 1'b0);
    send_item(tpr_pkg::KIND_APPEND, 16'hFFFF, 16'h7FFF, 16'h0, 16'h0);
    repeat (3) send_attempt();
    drain();

    // Random phases under different idling
    random_phase(150);
    send_idle_pct = 86;
    random_phase(100);
    send_idle_pct = 0;
    recv_stall_pct = 86;
    random_phase(100);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    random_phase(100);
    // Long receiver hold-off while items keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    random_phase(60);
    load_table(256, 1'b1);
    repeat (5) send_attempt();
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tabulated_pdf_rejection_sampler_core: match");
    end else begin
      $display("tabulated_pdf_rejection_sampler_core: mismatch");
    end
    $finish;
  end
endmodule
